// ----- rtl/core/eccpm_pkg.sv -----
// ----------------------------------------------------------------------------
// eccpm_pkg
// Shared types and constants for the elliptic curve scalar point multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package eccpm_pkg;

   // Default field width in bits.
   localparam int FIELD_WIDTH_DEF = 64;

   // Width of the port words and of the configuration data.
   localparam int WORD_WIDTH = 64;

   // Register reset values.
   localparam logic [WORD_WIDTH-1:0] PRIME_RESET = 64'd23;
   localparam logic [WORD_WIDTH-1:0] COEFF_RESET = 64'd1;

   // Configuration register indexes.
   typedef enum logic {
      CSR_PRIME = 1'b0,
      CSR_COEFF = 1'b1
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_X,
      ST_RED_Y,
      ST_LOOP,
      ST_PA_START,
      ST_DB_SQ,
      ST_DB_3,
      ST_DB_A,
      ST_INV_TEST,
      ST_INV_DIV,
      ST_INV_MUL,
      ST_INV_UPD,
      ST_SLOPE,
      ST_X_SQ,
      ST_X_SUB1,
      ST_X_SUB2,
      ST_Y_MUL,
      ST_Y_SUB,
      ST_DONE
   } state_type;

   // Handshake of an arithmetic unit toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

`default_nettype wire

// ----- rtl/core/eccpm_mod_mul.sv -----
// ----------------------------------------------------------------------------
// eccpm_mod_mul
// Bit-serial modular multiplier: double-and-add, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eccpm_mod_mul
   import eccpm_pkg::*;
#(
   parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   mul_start,
   input  wire logic [FIELD_WIDTH-1:0] mul_x,
   input  wire logic [FIELD_WIDTH-1:0] mul_y,
   input  wire logic [FIELD_WIDTH-1:0] mul_p,
   output      unit_status_type        mul_status,
   output      logic [FIELD_WIDTH-1:0] mul_prod
);

   localparam int W  = FIELD_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  acc_ff;
   logic [W-1:0]  x_ff;
   logic [W-1:0]  y_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W-1:0]  dbl_in;
   logic [W-1:0]  acc_in;

   // Modular add of two values already below p.
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                            input logic [W-1:0] p);
      logic [W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[W-1:0];
   endfunction

   // One step: double the accumulator, then add x when the top bit of y is set.
   always_comb begin
      dbl_in = add_mod(acc_ff, acc_ff, mul_p);
      acc_in = y_ff[W-1] ? add_mod(dbl_in, x_ff, mul_p) : dbl_in;
   end

   // Control: counter, busy and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (mul_start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (mul_start && !busy_ff) begin
         acc_ff <= '0;
         x_ff   <= mul_x;
         y_ff   <= mul_y;
      end else if (busy_ff) begin
         acc_ff <= acc_in;
         y_ff   <= {y_ff[W-2:0], 1'b0};
      end
   end

   assign mul_status.busy = busy_ff;
   assign mul_status.done = done_ff;
   assign mul_prod        = acc_ff;

endmodule

`default_nettype wire

// ----- rtl/core/eccpm_div.sv -----
// ----------------------------------------------------------------------------
// eccpm_div
// Bit-serial restoring divider: one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eccpm_div
   import eccpm_pkg::*;
#(
   parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   div_start,
   input  wire logic [FIELD_WIDTH-1:0] div_dividend,
   input  wire logic [FIELD_WIDTH-1:0] div_divisor,
   output      unit_status_type        div_status,
   output      logic [FIELD_WIDTH-1:0] div_quot,
   output      logic [FIELD_WIDTH-1:0] div_rem
);

   localparam int W  = FIELD_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W:0]    rem_ff;
   logic [W-1:0]  quo_ff;
   logic [W-1:0]  dvs_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [W:0]    trial_in;
   logic          fits_in;

   // Shift in the next dividend bit and try the subtraction.
   always_comb begin
      trial_in = {rem_ff[W-1:0], quo_ff[W-1]};
      fits_in  = (trial_in >= {1'b0, dvs_ff});
   end

   // Control: counter, busy and done pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: the dividend register turns into the quotient as it shifts.
   always_ff @(posedge clock) begin
      if (div_start && !busy_ff) begin
         rem_ff <= '0;
         quo_ff <= div_dividend;
         dvs_ff <= div_divisor;
      end else if (busy_ff) begin
         rem_ff <= fits_in ? (trial_in - {1'b0, dvs_ff}) : trial_in;
         quo_ff <= {quo_ff[W-2:0], fits_in};
      end
   end

   assign div_status.busy = busy_ff;
   assign div_status.done = done_ff;
   assign div_quot        = quo_ff;
   assign div_rem         = rem_ff[W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/ec_scalar_point_multiply.sv -----
// ----------------------------------------------------------------------------
// ec_scalar_point_multiply
// Scalar multiple of an affine point by right-to-left double-and-add, with
// modular inverses from an extended Euclid loop.
// ----------------------------------------------------------------------------
// Each modular multiply or divide holds the sequencer until it is done; an inverse
// takes one divide and one multiply per extended Euclid step. A scalar bit costs one
// or two point operations; a modulus below 3 goes straight to the result. One word
// is worked at a time; busy stays high through the rsp_valid cycle. Synchronous
// reset returns the sequencer to idle and loads p = 23, a = 1.
`default_nettype none

module ec_scalar_point_multiply
   import eccpm_pkg::*;
#(
   parameter int FIELD_WIDTH = FIELD_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [WORD_WIDTH-1:0] req_point_x,
   input  wire logic [WORD_WIDTH-1:0] req_point_y,
   input  wire logic [WORD_WIDTH-1:0] req_scalar,
   output      logic                  rsp_valid,
   output      logic [WORD_WIDTH-1:0] rsp_result_x,
   output      logic [WORD_WIDTH-1:0] rsp_result_y,
   output      logic                  rsp_at_infinity,
   input  wire logic                  csr_write_enable,
   input  wire logic                  csr_index,
   input  wire logic [WORD_WIDTH-1:0] csr_write_data
);

   localparam int W = FIELD_WIDTH;

   state_type       state_ff, state_in;
   logic [W-1:0]    p_ff, a_cfg_ff, a_ff;
   logic [W-1:0]    rx_ff, ry_ff, cx_ff, cy_ff, ux_ff, uy_ff, vx_ff, vy_ff;
   logic [W-1:0]    rawx_ff, rawy_ff;
   logic [WORD_WIDTH-1:0] k_ff;
   logic [W-1:0]    tmp_ff, num_ff, m_ff, x3_ff, inv_ff;
   logic [W-1:0]    r0_ff, r1_ff, t0_ff, t1_ff, q_ff, rem_ff;
   logic            dbl_ff;
   logic            issued_ff;
   logic            accept;

   logic            mul_start, div_start;
   logic [W-1:0]    mul_x, mul_y, div_dividend, div_divisor;
   unit_status_type mul_status, div_status;
   logic [W-1:0]    mul_prod, div_quot, div_rem;
   logic            unit_done;

   // Modular add of two values already below p.
   function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] p);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, p}) begin
         s = s - {1'b0, p};
      end
      return s[W-1:0];
   endfunction

   // Modular subtract of two values already below p.
   function automatic logic [W-1:0] sub_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] p);
      return (x >= y) ? (x - y) : (x - y + p);
   endfunction

   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff     <= PRIME_RESET[W-1:0];
         a_cfg_ff <= COEFF_RESET[W-1:0];
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRIME: p_ff     <= csr_write_data[W-1:0];
            CSR_COEFF: a_cfg_ff <= csr_write_data[W-1:0];
            default:   p_ff     <= p_ff;
         endcase
      end
   end

   // Arithmetic units.
   eccpm_mod_mul #(.FIELD_WIDTH(FIELD_WIDTH)) u_mul (
      .clock      (clock),
      .reset      (reset),
      .mul_start  (mul_start),
      .mul_x      (mul_x),
      .mul_y      (mul_y),
      .mul_p      (p_ff),
      .mul_status (mul_status),
      .mul_prod   (mul_prod)
   );

   eccpm_div #(.FIELD_WIDTH(FIELD_WIDTH)) u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_status   (div_status),
      .div_quot     (div_quot),
      .div_rem      (div_rem)
   );

   // Unit launch and operand selection per state.
   always_comb begin
      mul_start    = 1'b0;
      div_start    = 1'b0;
      mul_x        = m_ff;
      mul_y        = m_ff;
      div_dividend = a_cfg_ff;
      div_divisor  = p_ff;
      unique case (state_ff)
         ST_RED_A: begin
            div_start = !issued_ff;
         end
         ST_RED_X: begin
            div_start    = !issued_ff;
            div_dividend = rawx_ff;
         end
         ST_RED_Y: begin
            div_start    = !issued_ff;
            div_dividend = rawy_ff;
         end
         ST_INV_DIV: begin
            div_start    = !issued_ff;
            div_dividend = r0_ff;
            div_divisor  = r1_ff;
         end
         ST_DB_SQ: begin
            mul_start = !issued_ff;
            mul_x     = ux_ff;
            mul_y     = ux_ff;
         end
         ST_DB_3: begin
            mul_start = !issued_ff;
            mul_x     = W'(3);
            mul_y     = tmp_ff;
         end
         ST_INV_MUL: begin
            mul_start = !issued_ff;
            mul_x     = (q_ff == p_ff) ? '0 : q_ff;
            mul_y     = t1_ff;
         end
         ST_SLOPE: begin
            mul_start = !issued_ff;
            mul_x     = num_ff;
            mul_y     = inv_ff;
         end
         ST_X_SQ: begin
            mul_start = !issued_ff;
         end
         ST_Y_MUL: begin
            mul_start = !issued_ff;
            mul_y     = sub_mod(ux_ff, x3_ff, p_ff);
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   assign unit_done = mul_status.done || div_status.done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (p_ff < W'(3)) ? ST_DONE : ST_RED_A;
            end
         end
         ST_RED_A: if (unit_done) state_in = ST_RED_X;
         ST_RED_X: if (unit_done) state_in = ST_RED_Y;
         ST_RED_Y: if (unit_done) state_in = ST_LOOP;
         ST_LOOP: begin
            state_in = (k_ff == '0) ? ST_DONE : ST_PA_START;
         end
         ST_PA_START: begin
            priority if ((ux_ff == '0 && uy_ff == '0) || (vx_ff == '0 && vy_ff == '0)) begin
               state_in = dbl_ff ? ST_LOOP : ST_PA_START;
            end else if (ux_ff == vx_ff && uy_ff == vy_ff && uy_ff != '0) begin
               state_in = ST_DB_SQ;
            end else if (ux_ff == vx_ff) begin
               state_in = dbl_ff ? ST_LOOP : ST_PA_START;
            end else begin
               state_in = ST_INV_TEST;
            end
         end
         ST_DB_SQ:    if (unit_done) state_in = ST_DB_3;
         ST_DB_3:     if (unit_done) state_in = ST_DB_A;
         ST_DB_A:     state_in = ST_INV_TEST;
         ST_INV_TEST: state_in = (r1_ff == '0) ? ST_SLOPE : ST_INV_DIV;
         ST_INV_DIV:  if (unit_done) state_in = ST_INV_MUL;
         ST_INV_MUL:  if (unit_done) state_in = ST_INV_UPD;
         ST_INV_UPD:  state_in = ST_INV_TEST;
         ST_SLOPE:    if (unit_done) state_in = ST_X_SQ;
         ST_X_SQ:     if (unit_done) state_in = ST_X_SUB1;
         ST_X_SUB1:   state_in = ST_X_SUB2;
         ST_X_SUB2:   state_in = ST_Y_MUL;
         ST_Y_MUL:    if (unit_done) state_in = ST_Y_SUB;
         ST_Y_SUB:    state_in = dbl_ff ? ST_LOOP : ST_PA_START;
         ST_DONE:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // State and unit handshake registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (mul_start || div_start) begin
            issued_ff <= 1'b1;
         end else if (unit_done) begin
            issued_ff <= 1'b0;
         end
      end
   end

   // Datapath registers, written according to the state.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rawx_ff <= req_point_x[W-1:0];
               rawy_ff <= req_point_y[W-1:0];
               k_ff    <= req_scalar;
               rx_ff   <= '0;
               ry_ff   <= '0;
            end
         end
         ST_RED_A: if (unit_done) a_ff  <= div_rem;
         ST_RED_X: if (unit_done) cx_ff <= div_rem;
         ST_RED_Y: if (unit_done) cy_ff <= div_rem;
         ST_LOOP: begin
            // Add into the result when the low bit is set, else double.
            ux_ff  <= k_ff[0] ? rx_ff : cx_ff;
            uy_ff  <= k_ff[0] ? ry_ff : cy_ff;
            vx_ff  <= cx_ff;
            vy_ff  <= cy_ff;
            dbl_ff <= !k_ff[0];
         end
         ST_PA_START: begin
            priority if ((ux_ff == '0 && uy_ff == '0) || (vx_ff == '0 && vy_ff == '0)
                         || (ux_ff == vx_ff && (uy_ff != vy_ff || uy_ff == '0))) begin
               // Sum follows without a slope: an identity or infinity.
               logic [W-1:0] sx, sy;
               if (ux_ff == '0 && uy_ff == '0) begin
                  sx = vx_ff;
                  sy = vy_ff;
               end else if (vx_ff == '0 && vy_ff == '0) begin
                  sx = ux_ff;
                  sy = uy_ff;
               end else begin
                  sx = '0;
                  sy = '0;
               end
               if (dbl_ff) begin
                  cx_ff <= sx;
                  cy_ff <= sy;
                  k_ff  <= {1'b0, k_ff[WORD_WIDTH-1:1]};
               end else begin
                  rx_ff  <= sx;
                  ry_ff  <= sy;
                  ux_ff  <= cx_ff;
                  uy_ff  <= cy_ff;
                  dbl_ff <= 1'b1;
               end
            end else if (ux_ff != vx_ff) begin
               // Chord slope: (vy - uy) / (vx - ux).
               num_ff <= sub_mod(vy_ff, uy_ff, p_ff);
               r0_ff  <= p_ff;
               r1_ff  <= sub_mod(vx_ff, ux_ff, p_ff);
               t0_ff  <= '0;
               t1_ff  <= W'(1);
            end
         end
         ST_DB_SQ: if (unit_done) tmp_ff <= mul_prod;
         ST_DB_3:  if (unit_done) tmp_ff <= mul_prod;
         ST_DB_A: begin
            // Tangent slope: (3 x^2 + a) / (2 y).
            num_ff <= add_mod(tmp_ff, a_ff, p_ff);
            r0_ff  <= p_ff;
            r1_ff  <= add_mod(uy_ff, uy_ff, p_ff);
            t0_ff  <= '0;
            t1_ff  <= W'(1);
         end
         ST_INV_TEST: begin
            if (r1_ff == '0) begin
               inv_ff <= (r0_ff == W'(1)) ? t0_ff : '0;
            end
         end
         ST_INV_DIV: begin
            if (unit_done) begin
               q_ff   <= div_quot;
               rem_ff <= div_rem;
            end
         end
         ST_INV_MUL: if (unit_done) tmp_ff <= mul_prod;
         ST_INV_UPD: begin
            t0_ff <= t1_ff;
            t1_ff <= sub_mod(t0_ff, tmp_ff, p_ff);
            r0_ff <= r1_ff;
            r1_ff <= rem_ff;
         end
         ST_SLOPE:  if (unit_done) m_ff <= mul_prod;
         ST_X_SQ:   if (unit_done) tmp_ff <= mul_prod;
         ST_X_SUB1: tmp_ff <= sub_mod(tmp_ff, ux_ff, p_ff);
         ST_X_SUB2: x3_ff  <= sub_mod(tmp_ff, vx_ff, p_ff);
         ST_Y_MUL:  if (unit_done) tmp_ff <= mul_prod;
         ST_Y_SUB: begin
            if (dbl_ff) begin
               cx_ff <= x3_ff;
               cy_ff <= sub_mod(tmp_ff, uy_ff, p_ff);
               k_ff  <= {1'b0, k_ff[WORD_WIDTH-1:1]};
            end else begin
               rx_ff  <= x3_ff;
               ry_ff  <= sub_mod(tmp_ff, uy_ff, p_ff);
               ux_ff  <= cx_ff;
               uy_ff  <= cy_ff;
               dbl_ff <= 1'b1;
            end
         end
         default: begin
            m_ff <= m_ff;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      busy            = (state_ff != ST_IDLE);
      rsp_valid       = (state_ff == ST_DONE);
      rsp_result_x    = WORD_WIDTH'(rx_ff);
      rsp_result_y    = WORD_WIDTH'(ry_ff);
      rsp_at_infinity = (rx_ff == '0) && (ry_ff == '0);
   end

   // A started word makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after an accepted word");

   // The result word is a single-cycle pulse.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for more than one cycle");

   // The two arithmetic units never run at the same time.
   a_units_excl: assert property (@(posedge clock) disable iff (reset)
      !(mul_status.busy && div_status.busy))
      else $error("multiplier and divider busy together");

   // A unit finishes only while the sequencer waits on it.
   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> issued_ff)
      else $error("arithmetic unit finished without a request");

endmodule

`default_nettype wire
